// File: hw/rtl/ufcb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ufcb_pkg
// Shared types, codes and constants of the serial flow-control buffer.
// ----------------------------------------------------------------------------
package ufcb_pkg;

    localparam int RX_DEPTH_DEF  = 2048;
    localparam int TX_DEPTH_DEF  = 1024;
    localparam int MAX_BURST_DEF = 16;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    // command opcodes
    localparam logic [2:0] OP_RX_BYTE    = 3'd0;
    localparam logic [2:0] OP_HOST_WRITE = 3'd1;
    localparam logic [2:0] OP_HOST_READ  = 3'd2;
    localparam logic [2:0] OP_TX_EMPTY   = 3'd3;
    localparam logic [2:0] OP_MODEM      = 3'd4;
    localparam logic [2:0] OP_STATUS     = 3'd5;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FLOW_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_MARK = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_MARK  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TX_BURST  = 2'd3;

    localparam logic [11:0] HIGH_MARK_RST = 12'd1792;
    localparam logic [11:0] LOW_MARK_RST  = 12'd1024;

    localparam logic [7:0] CH_XON  = 8'h11;
    localparam logic [7:0] CH_XOFF = 8'h13;

    localparam logic [4:0] ERR_RX_SEEN = 5'h01;
    localparam logic [4:0] ERR_OVERRUN = 5'h02;

    // flow flag bit positions
    localparam int FL_SEND_FLOW  = 0;
    localparam int FL_FLOW_IS_ON = 1;
    localparam int FL_TX_SOFT    = 2;
    localparam int FL_TX_HARD    = 3;
    localparam int FL_RX_SOFT    = 4;
    localparam int FL_RX_HARD    = 5;
    localparam int FL_TX_WAIT    = 6;
    localparam int FL_TX_BUSY    = 7;

    // what a command sends on the line
    localparam logic [1:0] SEND_NONE = 2'd0;
    localparam logic [1:0] SEND_FLOW = 2'd1;
    localparam logic [1:0] SEND_DATA = 2'd2;

    typedef struct packed {
        logic [2:0] opcode;
        logic [7:0] data_byte;
        logic [3:0] line_errors;
        logic       line_tx_ready;
        logic       cts_in;
    } cmd_t;

    typedef struct packed {
        logic        tx_valid;
        logic [7:0]  tx_byte;
        logic        host_valid;
        logic [7:0]  host_byte;
        logic        accepted;
        logic        rts_out;
        logic [11:0] rx_fill;
        logic [4:0]  error_bits;
        logic        last;
    } result_t;

    typedef struct packed {
        logic [2:0]  flow_mode;
        logic [11:0] high_mark;
        logic [11:0] low_mark;
        logic [4:0]  tx_burst;
    } cfg_t;

    // decision of the flow logic for one command
    typedef struct packed {
        logic [7:0] flags;
        logic       rts;
        logic [4:0] sticky;
        logic [4:0] err_out;
        logic       host_valid;
        logic       accepted;
        logic       rx_push;
        logic       rx_pop;
        logic       tx_push;
        logic [1:0] send_kind;
        logic [7:0] flow_byte;
    } dec_t;

endpackage
`default_nettype wire

// File: hw/rtl/uart_flow_control_buffer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// uart_flow_control_buffer
// Receive and transmit byte rings with XON/XOFF and RTS/CTS flow control.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive cmd and pulse start; the command is taken at a
//   clock edge where start is high and busy is low.
//   Result channel: each result beat shows on result for one cycle with
//   result_valid high; result.last marks the final beat of a command. The
//   receiver cannot stall, so every beat must be taken when shown.
//   Configuration: cfg_index/cfg_data written when cfg_valid and cfg_ready
//   are high; cfg_ready is always high. Write only while busy is low.
// Sequence:
//   A command without a burst yields one beat, which ST_FETCH registers
//   onto result. A burst of N bytes yields N beats, one per cycle:
//   ST_FETCH issues the first ring read, then ST_BURST registers each
//   byte onto result; the transmit ring RAM read port delivers one byte
//   a cycle. busy is high from the cycle after the take until the last
//   beat shows. Receive and transmit bytes live in two synchronous RAMs;
//   counts, pointers and flags live in registers.
// Reset:
//   rst_n clears pointers, counts, flags and sticky errors, raises RTS and
//   loads default marks; ring contents are undefined until written.
// ----------------------------------------------------------------------------
module uart_flow_control_buffer
    import ufcb_pkg::*;
#(
    parameter int RX_DEPTH  = RX_DEPTH_DEF,
    parameter int TX_DEPTH  = TX_DEPTH_DEF,
    parameter int MAX_BURST = MAX_BURST_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire cmd_t                  cmd,
    output result_t                    result,
    output logic                       result_valid,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int RX_AW = $clog2(RX_DEPTH);
    localparam int TX_AW = $clog2(TX_DEPTH);
    localparam int RX_CW = $clog2(RX_DEPTH + 1);
    localparam int TX_CW = $clog2(TX_DEPTH + 1);
    localparam int BW    = $clog2(MAX_BURST + 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_FETCH = 2'd1;
    localparam logic [1:0] ST_BURST = 2'd2;

    logic [1:0]       state_reg, state_next;
    cfg_t             cfg_reg, cfg_next;
    logic [7:0]       flags_reg, flags_next;
    logic             rts_reg, rts_next;
    logic [4:0]       sticky_reg, sticky_next;
    logic [RX_AW-1:0] rx_rd_ptr_reg, rx_rd_ptr_next;
    logic [RX_AW-1:0] rx_wr_ptr_reg, rx_wr_ptr_next;
    logic [RX_CW-1:0] rx_cnt_reg, rx_cnt_next;
    logic [TX_AW-1:0] tx_rd_ptr_reg, tx_rd_ptr_next;
    logic [TX_AW-1:0] tx_wr_ptr_reg, tx_wr_ptr_next;
    logic [TX_CW-1:0] tx_cnt_reg, tx_cnt_next;
    logic [TX_AW-1:0] tx_addr_reg, tx_addr_next;
    logic [BW-1:0]    remain_reg, remain_next;
    logic [1:0]       kind_reg, kind_next;
    logic [7:0]       flow_byte_reg, flow_byte_next;
    result_t          hold_reg, hold_next;
    result_t          out_reg, out_next;
    logic             out_valid_reg, out_valid_next;

    logic             accept;
    dec_t             dec;
    logic [BW-1:0]    burst_len;
    logic [7:0]       rx_rdata;
    logic [7:0]       tx_rdata;
    logic             tx_re;
    logic [TX_AW:0]   tx_adv;
    logic [TX_AW:0]   tx_adv_wrap;
    logic [7:0]       host_byte_now;

    assign accept    = start && (state_reg == ST_IDLE);
    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;
    assign result       = out_reg;
    assign result_valid = out_valid_reg;

    ufcb_flow #(
        .RX_DEPTH  (RX_DEPTH),
        .TX_DEPTH  (TX_DEPTH),
        .MAX_BURST (MAX_BURST)
    ) u_flow (
        .cmd       (cmd),
        .cfg       (cfg_reg),
        .flags     (flags_reg),
        .rts       (rts_reg),
        .sticky    (sticky_reg),
        .rx_count  (rx_cnt_reg),
        .tx_count  (tx_cnt_reg),
        .dec       (dec),
        .burst_len (burst_len)
    );

    ufcb_ram #(
        .WIDTH (8),
        .DEPTH (RX_DEPTH)
    ) u_rx_ram (
        .clk   (clk),
        .we    (accept && dec.rx_push),
        .waddr (rx_wr_ptr_reg),
        .wdata (cmd.data_byte),
        .re    (accept && dec.rx_pop),
        .raddr (rx_rd_ptr_reg),
        .rdata (rx_rdata)
    );

    ufcb_ram #(
        .WIDTH (8),
        .DEPTH (TX_DEPTH)
    ) u_tx_ram (
        .clk   (clk),
        .we    (accept && dec.tx_push),
        .waddr (tx_wr_ptr_reg),
        .wdata (cmd.data_byte),
        .re    (tx_re),
        .raddr (tx_addr_reg),
        .rdata (tx_rdata)
    );

    // read pointer of the transmit ring after a burst
    assign tx_adv      = {1'b0, tx_rd_ptr_reg} + (TX_AW + 1)'(burst_len);
    assign tx_adv_wrap = (tx_adv >= (TX_AW + 1)'(TX_DEPTH))
                       ? tx_adv - (TX_AW + 1)'(TX_DEPTH) : tx_adv;

    assign host_byte_now = hold_reg.host_valid ? rx_rdata : 8'd0;

    assign tx_re = ((state_reg == ST_FETCH) && (kind_reg == SEND_DATA))
                || ((state_reg == ST_BURST) && (remain_reg != '0));

    // configuration writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_FLOW_MODE: cfg_next.flow_mode = cfg_data[2:0];
                REG_HIGH_MARK: cfg_next.high_mark = cfg_data[11:0];
                REG_LOW_MARK:  cfg_next.low_mark  = cfg_data[11:0];
                REG_TX_BURST:  cfg_next.tx_burst  = cfg_data[4:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    // ring state: all updates commit at the command edge
    always_comb
    begin
        flags_next     = flags_reg;
        rts_next       = rts_reg;
        sticky_next    = sticky_reg;
        rx_rd_ptr_next = rx_rd_ptr_reg;
        rx_wr_ptr_next = rx_wr_ptr_reg;
        rx_cnt_next    = rx_cnt_reg;
        tx_rd_ptr_next = tx_rd_ptr_reg;
        tx_wr_ptr_next = tx_wr_ptr_reg;
        tx_cnt_next    = tx_cnt_reg;
        if (accept)
        begin
            flags_next  = dec.flags;
            rts_next    = dec.rts;
            sticky_next = dec.sticky;
            if (dec.rx_push)
            begin
                rx_cnt_next    = rx_cnt_reg + 1'b1;
                rx_wr_ptr_next = (rx_wr_ptr_reg == RX_AW'(RX_DEPTH - 1))
                               ? '0 : rx_wr_ptr_reg + 1'b1;
            end
            if (dec.rx_pop)
            begin
                rx_cnt_next    = rx_cnt_reg - 1'b1;
                rx_rd_ptr_next = (rx_rd_ptr_reg == RX_AW'(RX_DEPTH - 1))
                               ? '0 : rx_rd_ptr_reg + 1'b1;
            end
            if (dec.tx_push)
            begin
                tx_wr_ptr_next = (tx_wr_ptr_reg == TX_AW'(TX_DEPTH - 1))
                               ? '0 : tx_wr_ptr_reg + 1'b1;
            end
            tx_cnt_next    = tx_cnt_reg + TX_CW'(dec.tx_push) - TX_CW'(burst_len);
            tx_rd_ptr_next = tx_adv_wrap[TX_AW-1:0];
        end
    end

    // sequencer: fetch, then emit one beat per cycle
    always_comb
    begin
        state_next     = state_reg;
        tx_addr_next   = tx_addr_reg;
        remain_next    = remain_reg;
        kind_next      = kind_reg;
        flow_byte_next = flow_byte_reg;
        hold_next      = hold_reg;
        out_next       = out_reg;
        out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    tx_addr_next   = tx_rd_ptr_reg;
                    remain_next    = burst_len;
                    kind_next      = dec.send_kind;
                    flow_byte_next = dec.flow_byte;
                    hold_next            = '0;
                    hold_next.host_valid = dec.host_valid;
                    hold_next.accepted   = dec.accepted;
                    hold_next.rts_out    = rts_next;
                    hold_next.rx_fill    = 12'(rx_cnt_next);
                    hold_next.error_bits = dec.err_out;
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                hold_next.host_byte = host_byte_now;
                out_next            = hold_reg;
                out_next.host_byte  = host_byte_now;
                if (kind_reg == SEND_DATA)
                begin
                    // first read of the burst; beats follow from ST_BURST
                    tx_addr_next = (tx_addr_reg == TX_AW'(TX_DEPTH - 1))
                                 ? '0 : tx_addr_reg + 1'b1;
                    remain_next  = remain_reg - 1'b1;
                    state_next   = ST_BURST;
                end
                else
                begin
                    out_next.tx_valid = (kind_reg == SEND_FLOW);
                    out_next.tx_byte  = (kind_reg == SEND_FLOW) ? flow_byte_reg : 8'd0;
                    out_next.last     = 1'b1;
                    out_valid_next    = 1'b1;
                    state_next        = ST_IDLE;
                end
            end
            ST_BURST:
            begin
                out_next          = hold_reg;
                out_next.tx_valid = 1'b1;
                out_next.tx_byte  = tx_rdata;
                out_next.last     = (remain_reg == '0);
                out_valid_next    = 1'b1;
                if (remain_reg != '0)
                begin
                    tx_addr_next = (tx_addr_reg == TX_AW'(TX_DEPTH - 1))
                                 ? '0 : tx_addr_reg + 1'b1;
                    remain_next  = remain_reg - 1'b1;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            cfg_reg.flow_mode  <= 3'd0;
            cfg_reg.high_mark  <= HIGH_MARK_RST;
            cfg_reg.low_mark   <= LOW_MARK_RST;
            cfg_reg.tx_burst   <= 5'd0;
            flags_reg          <= 8'd0;
            rts_reg            <= 1'b1;
            sticky_reg         <= 5'd0;
            rx_rd_ptr_reg      <= '0;
            rx_wr_ptr_reg      <= '0;
            rx_cnt_reg         <= '0;
            tx_rd_ptr_reg      <= '0;
            tx_wr_ptr_reg      <= '0;
            tx_cnt_reg         <= '0;
            remain_reg         <= '0;
            kind_reg           <= SEND_NONE;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            state_reg          <= state_next;
            cfg_reg            <= cfg_next;
            flags_reg          <= flags_next;
            rts_reg            <= rts_next;
            sticky_reg         <= sticky_next;
            rx_rd_ptr_reg      <= rx_rd_ptr_next;
            rx_wr_ptr_reg      <= rx_wr_ptr_next;
            rx_cnt_reg         <= rx_cnt_next;
            tx_rd_ptr_reg      <= tx_rd_ptr_next;
            tx_wr_ptr_reg      <= tx_wr_ptr_next;
            tx_cnt_reg         <= tx_cnt_next;
            remain_reg         <= remain_next;
            kind_reg           <= kind_next;
            out_valid_reg      <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        tx_addr_reg   <= tx_addr_next;
        flow_byte_reg <= flow_byte_next;
        hold_reg      <= hold_next;
        out_reg       <= out_next;
    end

`ifndef NO_ASSERTIONS
    a_rx_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rx_cnt_reg <= RX_CW'(RX_DEPTH))
        else $error("receive count beyond ring depth");

    a_tx_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        tx_cnt_reg <= TX_CW'(TX_DEPTH))
        else $error("transmit count beyond ring depth");

    a_no_beat_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> !result_valid)
        else $error("result beat one cycle after a command was taken");

    a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.last == !busy))
        else $error("last beat and busy disagree");
`endif

endmodule
`default_nettype wire

// File: hw/rtl/ufcb_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ufcb_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module ufcb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/ufcb_flow.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ufcb_flow
// Flow-control decision for one command: new flags, RTS, sticky errors,
// buffer pushes and pops, and what the send attempt puts on the line.
// ----------------------------------------------------------------------------
module ufcb_flow
    import ufcb_pkg::*;
#(
    parameter int RX_DEPTH  = RX_DEPTH_DEF,
    parameter int TX_DEPTH  = TX_DEPTH_DEF,
    parameter int MAX_BURST = MAX_BURST_DEF,
    localparam int RX_CW    = $clog2(RX_DEPTH + 1),
    localparam int TX_CW    = $clog2(TX_DEPTH + 1),
    localparam int BW       = $clog2(MAX_BURST + 1)
) (
    input  wire cmd_t             cmd,
    input  wire cfg_t             cfg,
    input  wire logic [7:0]       flags,
    input  wire logic             rts,
    input  wire logic [4:0]       sticky,
    input  wire logic [RX_CW-1:0] rx_count,
    input  wire logic [TX_CW-1:0] tx_count,
    output dec_t                  dec,
    output logic [BW-1:0]         burst_len
);

    localparam int CMPW = (RX_CW > 12) ? RX_CW : 12;
    localparam int LW   = (BW > 5) ? BW : 5;
    localparam int MW   = (TX_CW > LW) ? TX_CW : LW;

    logic [7:0]       f;
    logic [4:0]       st;
    logic             rts_n;
    logic             try_go;
    logic [TX_CW-1:0] txc;
    logic [RX_CW-1:0] rx_after_pop;
    logic             hi_hit;
    logic             lo_hit;
    logic             rx_full;
    logic             tx_full;
    logic             soft_rx;
    logic [LW-1:0]    lim_raw;
    logic [LW-1:0]    lim;

    assign rx_after_pop = rx_count - 1'b1;
    assign hi_hit  = CMPW'(rx_count) >= CMPW'(cfg.high_mark);
    assign lo_hit  = CMPW'(rx_after_pop) <= CMPW'(cfg.low_mark);
    assign rx_full = rx_count >= RX_CW'(RX_DEPTH);
    assign tx_full = tx_count >= TX_CW'(TX_DEPTH);
    assign soft_rx = cfg.flow_mode[0] && !cfg.flow_mode[2];
    assign lim_raw = (cfg.tx_burst == 5'd0) ? LW'(1) : LW'(cfg.tx_burst);
    assign lim     = (lim_raw > LW'(MAX_BURST)) ? LW'(MAX_BURST) : lim_raw;

    always_comb
    begin
        f              = flags;
        st             = sticky;
        rts_n          = rts;
        try_go         = 1'b0;
        txc            = tx_count;
        dec            = '0;
        burst_len      = '0;

        case (cmd.opcode)
            OP_RX_BYTE:
            begin
                if (soft_rx && cmd.data_byte == CH_XON)
                begin
                    f[FL_TX_SOFT] = 1'b0;
                    try_go = flags[FL_TX_WAIT] || cmd.line_tx_ready;
                end
                else if (soft_rx && cmd.data_byte == CH_XOFF)
                begin
                    f[FL_TX_SOFT] = 1'b1;
                    try_go = cmd.line_tx_ready;
                end
                else
                begin
                    if (cfg.flow_mode[0] && !f[FL_RX_SOFT] && hi_hit)
                    begin
                        f[FL_RX_SOFT]    = 1'b1;
                        f[FL_SEND_FLOW]  = 1'b1;
                        f[FL_FLOW_IS_ON] = 1'b0;
                        try_go = !f[FL_TX_BUSY];
                    end
                    if (cfg.flow_mode[1] && !f[FL_RX_HARD] && hi_hit)
                    begin
                        f[FL_RX_HARD] = 1'b1;
                        rts_n = 1'b0;
                    end
                    st = st | ERR_RX_SEEN | {cmd.line_errors, 1'b0};
                    if (rx_full)
                    begin
                        st = st | ERR_OVERRUN;
                    end
                    else
                    begin
                        dec.rx_push = 1'b1;
                    end
                    // a forced attempt merges with one already made
                    try_go = try_go || cmd.line_tx_ready;
                end
            end
            OP_HOST_WRITE:
            begin
                if (!tx_full)
                begin
                    dec.tx_push  = 1'b1;
                    dec.accepted = 1'b1;
                    txc = tx_count + 1'b1;
                    try_go = !f[FL_TX_BUSY];
                end
            end
            OP_HOST_READ:
            begin
                if (rx_count != '0)
                begin
                    dec.host_valid = 1'b1;
                    dec.rx_pop     = 1'b1;
                    if (cfg.flow_mode[1:0] != 2'b00 && lo_hit)
                    begin
                        if (f[FL_RX_SOFT])
                        begin
                            f[FL_RX_SOFT]    = 1'b0;
                            f[FL_SEND_FLOW]  = 1'b1;
                            f[FL_FLOW_IS_ON] = 1'b1;
                            try_go = !f[FL_TX_BUSY];
                        end
                        if (f[FL_RX_HARD])
                        begin
                            f[FL_RX_HARD] = 1'b0;
                            rts_n = 1'b1;
                        end
                    end
                end
            end
            OP_TX_EMPTY:
            begin
                try_go = 1'b1;
            end
            OP_MODEM:
            begin
                if (cfg.flow_mode[1])
                begin
                    if (cmd.cts_in)
                    begin
                        f[FL_TX_HARD] = 1'b0;
                        try_go = f[FL_TX_WAIT];
                    end
                    else
                    begin
                        f[FL_TX_HARD] = 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase

        // send attempt: flow byte first, else a burst of queued data
        if (try_go)
        begin
            if (f[FL_SEND_FLOW])
            begin
                f[FL_SEND_FLOW] = 1'b0;
                f[FL_TX_BUSY]   = 1'b1;
                dec.send_kind   = SEND_FLOW;
                dec.flow_byte   = f[FL_FLOW_IS_ON] ? CH_XON : CH_XOFF;
            end
            else
            begin
                f[FL_TX_BUSY] = 1'b0;
                f[FL_TX_WAIT] = (txc != '0);
                if (txc != '0 && !f[FL_TX_SOFT] && !f[FL_TX_HARD])
                begin
                    f[FL_TX_WAIT] = 1'b0;
                    f[FL_TX_BUSY] = 1'b1;
                    dec.send_kind = SEND_DATA;
                    burst_len = (MW'(txc) > MW'(lim)) ? BW'(lim) : BW'(txc);
                end
            end
        end

        dec.flags   = f;
        dec.rts     = rts_n;
        dec.err_out = st;
        dec.sticky  = (cmd.opcode == OP_STATUS) ? 5'd0 : st;
    end

endmodule
`default_nettype wire
